FILE: design/sdq_pkg.sv
// Shared types and constants for the sorted delay queue.
package sdq_pkg;

  // Default sizing
  localparam int unsigned DefMaxWaiting = 16;
  localparam int unsigned DefTickBits   = 32;

  // Field widths fixed by the interface
  localparam int unsigned IdBits    = 8;
  localparam int unsigned TickField = 32;

  // Input item codes
  localparam logic FuncAdd  = 1'b0;
  localparam logic FuncTick = 1'b1;

  // Result status codes
  localparam logic StatusWoken   = 1'b0;
  localparam logic StatusRefused = 1'b1;

  // Input beat
  typedef struct packed {
    logic                 func;
    logic [IdBits-1:0]    task_id;
    logic [TickField-1:0] tick_value;
  } in_t;

  // Output beat
  typedef struct packed {
    logic [IdBits-1:0] woken_id;
    logic              status;
    logic              last;
  } out_t;

endpackage

FILE: design/sdq_mem.sv
// Entry store: one write port, one registered read port.
module sdq_mem #(
  parameter int unsigned Depth    = sdq_pkg::DefMaxWaiting,
  parameter int unsigned WakeBits = sdq_pkg::DefTickBits,
  localparam int unsigned AW      = $clog2(Depth)
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [AW-1:0]             waddr_i,
  input  logic [WakeBits-1:0]       wwake_i,
  input  logic [sdq_pkg::IdBits-1:0] wtask_i,
  input  logic [AW-1:0]             raddr_i,
  output logic [WakeBits-1:0]       rwake_o,
  output logic [sdq_pkg::IdBits-1:0] rtask_o
);

  logic [WakeBits-1:0]        wake_mem [Depth];
  logic [sdq_pkg::IdBits-1:0] task_mem [Depth];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      wake_mem[waddr_i] <= wwake_i;
      task_mem[waddr_i] <= wtask_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rwake_o <= wake_mem[raddr_i];
    rtask_o <= task_mem[raddr_i];
  end

endmodule

FILE: design/sdq_cmp.sv
// Shared unsigned less-or-equal compare of a stored wake tick against the key.
module sdq_cmp #(
  parameter int unsigned Bits = sdq_pkg::DefTickBits
) (
  input  logic [Bits-1:0] wake_i,
  input  logic [Bits-1:0] key_i,
  output logic            le_o
);

  assign le_o = (wake_i <= key_i);

endmodule

FILE: design/sorted_delay_queue_core.sv
// Top level of the sorted delay queue: sequencer, pointers and output register.
//
// Keeps waiting task ids in a circular store ordered by wake tick.
// Input channel (in_valid_i / in_stall_o / in_data_i): an add beat inserts
// task_id after every entry with wake tick <= its own; a tick beat removes
// every entry whose wake tick is <= the given tick. in_stall_o is high
// whenever an item is in progress; one item is worked on at a time.
// Output channel (out_valid_o / out_stall_i / out_data_o): one beat per woken
// task in queue order, last set on the final one; an add to a full queue
// gives a single refusal beat. A successful add or a tick that expires
// nothing gives no beat.
// An add shifts each entry with a later wake tick one slot toward the tail;
// a tick removes the woken tasks from the head. Both are paced by the single
// compare unit stepping through the store at one entry per cycle (unless
// held by out_stall_i) over its one write port and one registered read port.
// The output register lets the sequencer load a beat while the previous one
// is taken in the same cycle; while out_stall_i holds a beat, a refusal or
// tick step waits in place. Reset empties the queue at once; no clearing pass.
module sorted_delay_queue_core #(
  parameter int unsigned MaxWaiting = sdq_pkg::DefMaxWaiting,
  parameter int unsigned TickBits   = sdq_pkg::DefTickBits
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  sdq_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output sdq_pkg::out_t out_data_o
);

  localparam int unsigned AW = $clog2(MaxWaiting);
  localparam int unsigned CW = $clog2(MaxWaiting + 1);

  // Sequencer states
  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_INS_CMP = 3'd1;
  localparam logic [2:0] S_INS_WR  = 3'd2;
  localparam logic [2:0] S_REFUSE  = 3'd3;
  localparam logic [2:0] S_TK_CMP  = 3'd4;

  logic [2:0] state_q, state_d;
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] pos_q, pos_d;
  logic [CW-1:0] left_q, left_d;
  logic [TickBits-1:0] key_q, key_d;
  logic [sdq_pkg::IdBits-1:0] id_q, id_d;
  logic pend_valid_q, pend_valid_d;
  logic [sdq_pkg::IdBits-1:0] pend_id_q, pend_id_d;
  logic out_valid_q, out_valid_d;
  sdq_pkg::out_t out_data_q, out_data_d;

  // Memory port signals
  logic                       we;
  logic [AW-1:0]              waddr;
  logic [TickBits-1:0]        wwake;
  logic [sdq_pkg::IdBits-1:0] wtask;
  logic [AW-1:0]              raddr;
  logic [TickBits-1:0]        rwake;
  logic [sdq_pkg::IdBits-1:0] rtask;
  logic                       le;

  logic          in_acc;
  logic          can_load;
  logic [AW:0]   tail_sum;
  logic [AW-1:0] tail;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == AW'(MaxWaiting - 1)) ? '0 : AW'(p + 1'b1);
  endfunction

  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
    ptr_dec = (p == '0) ? AW'(MaxWaiting - 1) : AW'(p - 1'b1);
  endfunction

  sdq_mem #(
    .Depth    (MaxWaiting),
    .WakeBits (TickBits)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wwake_i (wwake),
    .wtask_i (wtask),
    .raddr_i (raddr),
    .rwake_o (rwake),
    .rtask_o (rtask)
  );

  sdq_cmp #(
    .Bits (TickBits)
  ) u_cmp (
    .wake_i (rwake),
    .key_i  (key_q),
    .le_o   (le)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign can_load    = !out_valid_q || !out_stall_i;

  // Slot just past the tail-most entry (latest wake tick)
  assign tail_sum = {1'b0, head_q} + (AW + 1)'(count_q);
  assign tail     = (tail_sum >= (AW + 1)'(MaxWaiting)) ?
                    AW'(tail_sum - (AW + 1)'(MaxWaiting)) : AW'(tail_sum);

  // Sequencer
  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    count_d      = count_q;
    pos_d        = pos_q;
    left_d       = left_q;
    key_d        = key_q;
    id_d         = id_q;
    pend_valid_d = pend_valid_q;
    pend_id_d    = pend_id_q;
    out_data_d   = out_data_q;
    out_valid_d  = out_valid_q && out_stall_i;
    we           = 1'b0;
    waddr        = pos_q;
    wwake        = key_q;
    wtask        = id_q;
    raddr        = head_q;

    unique case (state_q)
      S_IDLE: begin
        raddr = (in_data_i.func == sdq_pkg::FuncAdd) ? ptr_dec(tail) : head_q;
        if (in_acc) begin
          key_d = TickBits'(in_data_i.tick_value);
          id_d  = in_data_i.task_id;
          if (in_data_i.func == sdq_pkg::FuncAdd) begin
            pos_d  = tail;
            left_d = count_q;
            if (count_q == CW'(MaxWaiting)) begin
              state_d = S_REFUSE;
            end else if (count_q == '0) begin
              state_d = S_INS_WR;
            end else begin
              state_d = S_INS_CMP;
            end
          end else begin
            pend_valid_d = 1'b0;
            state_d      = S_TK_CMP;
          end
        end
      end

      // rwake/rtask hold the entry just below pos_q
      S_INS_CMP: begin
        raddr = ptr_dec(ptr_dec(pos_q));
        we    = 1'b1;
        if (le) begin
          count_d = CW'(count_q + 1'b1);
          state_d = S_IDLE;
        end else begin
          wwake  = rwake;
          wtask  = rtask;
          pos_d  = ptr_dec(pos_q);
          left_d = CW'(left_q - 1'b1);
          if (left_q == CW'(1)) begin
            state_d = S_INS_WR;
          end
        end
      end

      S_INS_WR: begin
        we      = 1'b1;
        count_d = CW'(count_q + 1'b1);
        state_d = S_IDLE;
      end

      S_REFUSE: begin
        if (can_load) begin
          out_valid_d = 1'b1;
          out_data_d  = '{woken_id: id_q, status: sdq_pkg::StatusRefused, last: 1'b1};
          state_d     = S_IDLE;
        end
      end

      // rwake/rtask hold the head entry; one pending result is held back
      // until the next compare tells whether it is the last
      S_TK_CMP: begin
        if ((count_q != '0) && le) begin
          if (!pend_valid_q || can_load) begin
            if (pend_valid_q) begin
              out_valid_d = 1'b1;
              out_data_d  = '{woken_id: pend_id_q, status: sdq_pkg::StatusWoken,
                              last: 1'b0};
            end
            pend_valid_d = 1'b1;
            pend_id_d    = rtask;
            head_d       = ptr_inc(head_q);
            count_d      = CW'(count_q - 1'b1);
          end
        end else if (pend_valid_q) begin
          if (can_load) begin
            out_valid_d  = 1'b1;
            out_data_d   = '{woken_id: pend_id_q, status: sdq_pkg::StatusWoken,
                             last: 1'b1};
            pend_valid_d = 1'b0;
            state_d      = S_IDLE;
          end
        end else begin
          state_d = S_IDLE;
        end
        raddr = head_d;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      head_q       <= '0;
      count_q      <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      head_q       <= head_d;
      count_q      <= count_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    pos_q      <= pos_d;
    left_q     <= left_d;
    key_q      <= key_d;
    id_q       <= id_d;
    pend_id_q  <= pend_id_d;
    out_data_q <= out_data_d;
  end

  // Fill level never passes the store depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MaxWaiting))
    else $error("queue count exceeds depth");

  // A refusal is always the single, final beat of its item
  a_refuse_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_data_q.status == sdq_pkg::StatusRefused) |-> out_data_q.last)
    else $error("refusal beat without last");

  // Finishing an insert through S_INS_WR adds exactly one entry
  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INS_WR) |=> (count_q == CW'($past(count_q) + 1'b1)))
    else $error("insert did not grow queue by one");

  // A tick never grows the queue
  a_tick_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TK_CMP) |=> (count_q <= $past(count_q)))
    else $error("tick grew the queue");

endmodule
